// ----- hw/rtl/mwsg_pkg.sv -----
// Package for the multi-waveform signal generator: sizes, mode and register codes,
// the configuration struct and the quarter-wave sine table built at elaboration.
// Depends on nothing; every other file of the block uses it.
package mwsg_pkg;

   localparam int SINE_ADDR_BITS  = 10;
   localparam int SINE_VALUE_BITS = 16;
   localparam int PHASE_BITS      = 34;
   localparam int SAMPLE_BITS     = 32;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 32;

   localparam int QUARTER_BITS = SINE_ADDR_BITS - 2;
   localparam int QUARTER_SIZE = 2 ** QUARTER_BITS;

   localparam logic [SINE_VALUE_BITS-1:0] SINE_MAX = {SINE_VALUE_BITS{1'b1}};
   localparam logic [SINE_VALUE_BITS-1:0] SINE_MID = {1'b1, {(SINE_VALUE_BITS-1){1'b0}}};

   // folds of the divide by 2^V-1: enough to bring the remainder to at most 2^V
   localparam int FOLD_STAGES = (SAMPLE_BITS + SINE_VALUE_BITS - 1) / SINE_VALUE_BITS + 2;
   localparam int FOLD_FIRST  = 3;
   localparam int FOLD_LAST   = FOLD_FIRST + FOLD_STAGES - 1;
   localparam int SHAPE_STAGES = FOLD_LAST + 2;

   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1073741824;

   typedef enum logic [1:0] {
      MODE_SINE   = 2'd0,
      MODE_SAW    = 2'd1,
      MODE_SQUARE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE      = 3'd0,
      CSR_AMPLITUDE = 3'd1,
      CSR_FREQUENCY = 3'd2,
      CSR_OFFSET    = 3'd3,
      CSR_POSITION  = 3'd4
   } csr_index_type;

   typedef struct packed {
      mode_type                 mode;
      logic [SAMPLE_BITS-1:0]   amplitude;
      logic [SAMPLE_BITS-1:0]   frequency_word;
      logic [SAMPLE_BITS-1:0]   phase_offset;
      logic [SAMPLE_BITS-1:0]   lift;
   } cfg_type;

   // table entry: {exact, floor(SINE_MAX * s / 2^31)}, s = sine in Q30
   typedef logic [SINE_VALUE_BITS-1:0] sine_entry_type;
   typedef logic [QUARTER_SIZE-1:0][SINE_VALUE_BITS-1:0] sine_rom_type;

   function automatic logic [30:0] quarter_sine_q30(input logic [QUARTER_BITS:0] m);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      x    = (64'(m) * PI_HALF_Q30) >> QUARTER_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd272;
      sum  = sum + $signed(term);
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      return 31'(sum);
   endfunction

   function automatic sine_entry_type sine_entry(input logic [QUARTER_BITS:0] m);
      longint unsigned prod;
      prod = 64'(SINE_MAX) * 64'(quarter_sine_q30(m));
      return {prod[30:0] == 31'd0, prod[31 +: SINE_VALUE_BITS-1]};
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int m = 0; m < QUARTER_SIZE; m++) begin
         rom[m] = sine_entry((QUARTER_BITS+1)'(m));
      end
      return rom;
   endfunction

   localparam sine_rom_type   SINE_ROM  = build_sine_rom();
   localparam sine_entry_type SINE_PEAK = sine_entry((QUARTER_BITS+1)'(QUARTER_SIZE));

endpackage

// ----- hw/rtl/mwsg_csr.sv -----
// Configuration registers of the signal generator and the registered lift term
// (headroom times position over 2^32-1). Depends on mwsg_pkg.
module mwsg_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [mwsg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mwsg_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   output mwsg_pkg::cfg_type                     cfg
);

   localparam logic [32:0] LIFT_ONE = 33'h0_FFFF_FFFF;
   localparam logic [32:0] LIFT_TWO = 33'h1_FFFF_FFFE;

   mwsg_pkg::mode_type mode_ff, mode_in;
   logic [31:0] amplitude_ff, amplitude_in;
   logic [31:0] frequency_ff, frequency_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] position_ff, position_in;
   logic [63:0] lift_prod_ff, lift_prod_in;
   logic [31:0] lift_high_ff, lift_high_in;
   logic [32:0] lift_sum_ff, lift_sum_in;
   logic [31:0] lift_ff, lift_in;
   logic [1:0]  lift_carry;

   always_comb begin
      mode_in      = mode_ff;
      amplitude_in = amplitude_ff;
      frequency_in = frequency_ff;
      offset_in    = offset_ff;
      position_in  = position_ff;
      if (csr_write_enable) begin
         unique case (mwsg_pkg::csr_index_type'(csr_index))
            mwsg_pkg::CSR_MODE:      mode_in = mwsg_pkg::mode_type'(csr_write_data[1:0]);
            mwsg_pkg::CSR_AMPLITUDE: amplitude_in = csr_write_data;
            mwsg_pkg::CSR_FREQUENCY: frequency_in = csr_write_data;
            mwsg_pkg::CSR_OFFSET:    offset_in = csr_write_data;
            mwsg_pkg::CSR_POSITION:  position_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // (2^32-1 - amp) * pos / (2^32-1): hi + floor((hi + lo) / (2^32-1))
   always_comb begin
      lift_prod_in = {32'd0, ~amplitude_ff} * {32'd0, position_ff};
      lift_high_in = lift_prod_ff[63:32];
      lift_sum_in  = 33'(lift_prod_ff[63:32]) + 33'(lift_prod_ff[31:0]);
      priority if (lift_sum_ff >= LIFT_TWO) begin
         lift_carry = 2'd2;
      end else if (lift_sum_ff >= LIFT_ONE) begin
         lift_carry = 2'd1;
      end else begin
         lift_carry = 2'd0;
      end
      lift_in = lift_high_ff + 32'(lift_carry);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= mwsg_pkg::MODE_SINE;
         amplitude_ff <= '0;
         frequency_ff <= '0;
         offset_ff    <= '0;
         position_ff  <= '0;
         lift_prod_ff <= '0;
         lift_high_ff <= '0;
         lift_sum_ff  <= '0;
         lift_ff      <= '0;
      end else begin
         mode_ff      <= mode_in;
         amplitude_ff <= amplitude_in;
         frequency_ff <= frequency_in;
         offset_ff    <= offset_in;
         position_ff  <= position_in;
         lift_prod_ff <= lift_prod_in;
         lift_high_ff <= lift_high_in;
         lift_sum_ff  <= lift_sum_in;
         lift_ff      <= lift_in;
      end
   end

   always_comb begin
      cfg.mode           = mode_ff;
      cfg.amplitude      = amplitude_ff;
      cfg.frequency_word = frequency_ff;
      cfg.phase_offset   = offset_ff;
      cfg.lift           = lift_ff;
   end

endmodule

// ----- hw/rtl/mwsg_phase.sv -----
// Phase accumulator and input stages: takes the request word, steps the
// accumulator and forms the output phase. Depends on mwsg_pkg.
module mwsg_phase (
   input  logic                                clock,
   input  logic                                reset,
   input  mwsg_pkg::cfg_type                   cfg,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_tick,
   output logic                                phase_valid,
   input  logic                                phase_ready,
   output logic [mwsg_pkg::PHASE_BITS-1:0]     phase
);

   logic [mwsg_pkg::PHASE_BITS-1:0] acc_ff, acc_in;
   logic [mwsg_pkg::PHASE_BITS-1:0] a_acc_ff, a_acc_in;
   logic [mwsg_pkg::PHASE_BITS-1:0] b_phase_ff, b_phase_in;
   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic a_en, b_en, accept;

   always_comb begin
      b_en      = !b_valid_ff || phase_ready;
      a_en      = !a_valid_ff || b_en;
      req_ready = a_en;
      accept    = req_valid && a_en;
      acc_in    = acc_ff;
      if (accept && req_tick) begin
         acc_in = acc_ff + mwsg_pkg::PHASE_BITS'(cfg.frequency_word);
      end
      a_valid_in = req_valid;
      a_acc_in   = acc_in;
      b_valid_in = a_valid_ff;
      b_phase_in = a_acc_ff + {cfg.phase_offset, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         if (a_en) begin
            a_valid_ff <= a_valid_in;
         end
         if (b_en) begin
            b_valid_ff <= b_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_acc_ff <= a_acc_in;
      end
      if (b_en) begin
         b_phase_ff <= b_phase_in;
      end
   end

   assign phase_valid = b_valid_ff;
   assign phase       = b_phase_ff;

   a_hold_acc : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_tick) |=> $stable(acc_ff))
      else $error("accumulator moved on a word without tick");

   a_step_acc : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_tick) |=>
         (acc_ff == $past(acc_ff) + mwsg_pkg::PHASE_BITS'($past(cfg.frequency_word))))
      else $error("accumulator did not step by the frequency word");

endmodule

// ----- hw/rtl/mwsg_shape.sv -----
// Waveform shaping pipeline: sine table lookup, sawtooth and square selection,
// amplitude multiply and the folded divide by 2^V-1. Depends on mwsg_pkg.
module mwsg_shape (
   input  logic                                clock,
   input  logic                                reset,
   input  mwsg_pkg::cfg_type                   cfg,
   input  logic                                phase_valid,
   output logic                                phase_ready,
   input  logic [mwsg_pkg::PHASE_BITS-1:0]     phase,
   output logic                                wave_valid,
   input  logic                                wave_ready,
   output logic [mwsg_pkg::SAMPLE_BITS-1:0]    wave
);

   localparam int V  = mwsg_pkg::SINE_VALUE_BITS;
   localparam int QB = mwsg_pkg::QUARTER_BITS;
   localparam int NF = mwsg_pkg::FOLD_STAGES;
   localparam int LAST = mwsg_pkg::SHAPE_STAGES - 1;

   logic [LAST:0] vld_ff, vld_in, en;

   logic [mwsg_pkg::SINE_ADDR_BITS-1:0] addr;
   logic [QB-1:0] rom_idx;
   logic          use_peak;

   mwsg_pkg::sine_entry_type c_entry_ff, c_entry_in;
   logic        c_neg_ff, c_neg_in;
   logic        c_high_ff, c_high_in;
   logic [31:0] c_frac_ff, c_frac_in;

   logic [V-1:0] level;
   logic [31:0]  d_operand_ff, d_operand_in;
   logic         d_high_ff, d_high_in;

   logic [63:0]  e_prod_ff, e_prod_in;
   logic         e_high_ff, e_high_in;

   logic [31:0]  q_ff [NF];
   logic [31:0]  q_in [NF];
   logic [32:0]  s_ff [NF];
   logic [32:0]  s_in [NF];

   logic [31:0]  w_wave_ff, w_wave_in;

   always_comb begin
      en[LAST] = !vld_ff[LAST] || wave_ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = phase_valid;
      for (int i = 1; i <= LAST; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   assign phase_ready = en[0];

   // quarter-wave lookup; the peak of the odd quadrants sits past the table end
   always_comb begin
      addr       = phase[mwsg_pkg::PHASE_BITS-1 -: mwsg_pkg::SINE_ADDR_BITS];
      rom_idx    = addr[QB] ? (QB'(0) - addr[QB-1:0]) : addr[QB-1:0];
      use_peak   = addr[QB] && (addr[QB-1:0] == '0);
      c_entry_in = use_peak ? mwsg_pkg::SINE_PEAK : mwsg_pkg::SINE_ROM[rom_idx];
      c_neg_in   = addr[QB+1];
      c_high_in  = !phase[mwsg_pkg::PHASE_BITS-1];
      c_frac_in  = phase[mwsg_pkg::PHASE_BITS-1:2];
   end

   always_comb begin
      if (c_neg_ff) begin
         level = mwsg_pkg::SINE_MID - {1'b0, c_entry_ff[V-2:0]} - V'(!c_entry_ff[V-1]);
      end else begin
         level = mwsg_pkg::SINE_MID + {1'b0, c_entry_ff[V-2:0]};
      end
      d_operand_in = (cfg.mode == mwsg_pkg::MODE_SINE) ? 32'(level) : c_frac_ff;
      d_high_in    = c_high_ff;
      e_prod_in    = 64'(cfg.amplitude) * 64'(d_operand_ff);
      e_high_in    = d_high_ff;
   end

   // x / (2^V-1): each fold adds x >> V to the quotient and keeps (x >> V) + (x mod 2^V)
   always_comb begin
      unique case (cfg.mode)
         mwsg_pkg::MODE_SINE: begin
            q_in[0] = 32'(e_prod_ff >> V);
            s_in[0] = 33'(e_prod_ff >> V) + 33'(e_prod_ff[V-1:0]);
         end
         mwsg_pkg::MODE_SAW: begin
            q_in[0] = e_prod_ff[63:32];
            s_in[0] = '0;
         end
         mwsg_pkg::MODE_SQUARE: begin
            q_in[0] = e_high_ff ? cfg.amplitude : '0;
            s_in[0] = '0;
         end
         mwsg_pkg::MODE_NONE: begin
            q_in[0] = '0;
            s_in[0] = '0;
         end
         default: begin
            q_in[0] = '0;
            s_in[0] = '0;
         end
      endcase
      for (int k = 1; k < NF; k++) begin
         q_in[k] = q_ff[k-1] + 32'(s_ff[k-1] >> V);
         s_in[k] = 33'(s_ff[k-1] >> V) + 33'(s_ff[k-1][V-1:0]);
      end
      w_wave_in = q_ff[NF-1] + 32'(s_ff[NF-1] >= 33'(mwsg_pkg::SINE_MAX));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i <= LAST; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         c_entry_ff <= c_entry_in;
         c_neg_ff   <= c_neg_in;
         c_high_ff  <= c_high_in;
         c_frac_ff  <= c_frac_in;
      end
      if (en[1]) begin
         d_operand_ff <= d_operand_in;
         d_high_ff    <= d_high_in;
      end
      if (en[2]) begin
         e_prod_ff <= e_prod_in;
         e_high_ff <= e_high_in;
      end
      for (int k = 0; k < NF; k++) begin
         if (en[mwsg_pkg::FOLD_FIRST + k]) begin
            q_ff[k] <= q_in[k];
            s_ff[k] <= s_in[k];
         end
      end
      if (en[LAST]) begin
         w_wave_ff <= w_wave_in;
      end
   end

   assign wave_valid = vld_ff[LAST];
   assign wave       = w_wave_ff;

   a_fold_bound : assert property (@(posedge clock) disable iff (reset)
      vld_ff[mwsg_pkg::FOLD_LAST] |->
         (s_ff[NF-1] <= 33'(mwsg_pkg::SINE_MAX) + 33'd1))
      else $error("divide remainder not reduced by the last fold");

   a_hold_last : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAST] && !wave_ready) |=> vld_ff[LAST])
      else $error("waveform word dropped while stalled");

endmodule

// ----- hw/rtl/multi_waveform_signal_generator.sv -----
// Top level of the multi-waveform signal generator: configuration registers,
// phase stages, shaping pipeline and the output register. Depends on mwsg_pkg.
//
// Takes one request word per clock and returns one sample word per request, in
// order; with the output taken every cycle it sustains one word per clock.
// A request passes through two phase stages, table lookup, operand select, the
// 32x32 amplitude multiply, ceil(32/V)+2 fold stages of the divide by 2^V-1,
// the final remainder correction and the saturating output add. Empty stages
// close up, so requests are taken while a finished sample waits. A tick of 1
// steps the 34-bit accumulator by the frequency word before the sample is
// formed. Register writes take effect for requests taken from the next cycle;
// the lift term follows a write of amplitude or position through the product,
// sum and lift registers.
module multi_waveform_signal_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_tick,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mwsg_pkg::SAMPLE_BITS-1:0]      rsp_sample,
   input  logic                                  csr_write_enable,
   input  logic [mwsg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mwsg_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   mwsg_pkg::cfg_type cfg;

   logic                                phase_valid, phase_ready;
   logic [mwsg_pkg::PHASE_BITS-1:0]     phase;
   logic                                wave_valid, wave_ready;
   logic [mwsg_pkg::SAMPLE_BITS-1:0]    wave;
   logic [mwsg_pkg::SAMPLE_BITS:0]      total;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [mwsg_pkg::SAMPLE_BITS-1:0]    rsp_sample_ff, rsp_sample_in;
   logic                                out_en;

   mwsg_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   mwsg_phase u_phase (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_tick    (req_tick),
      .phase_valid (phase_valid),
      .phase_ready (phase_ready),
      .phase       (phase)
   );

   mwsg_shape u_shape (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .phase_valid (phase_valid),
      .phase_ready (phase_ready),
      .phase       (phase),
      .wave_valid  (wave_valid),
      .wave_ready  (wave_ready),
      .wave        (wave)
   );

   always_comb begin
      out_en        = !rsp_valid_ff || rsp_ready;
      wave_ready    = out_en;
      rsp_valid_in  = wave_valid;
      total         = (mwsg_pkg::SAMPLE_BITS+1)'(wave) + (mwsg_pkg::SAMPLE_BITS+1)'(cfg.lift);
      rsp_sample_in = total[mwsg_pkg::SAMPLE_BITS] ? '1 : total[mwsg_pkg::SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

// ----- bench/multi_waveform_signal_generator_tb.sv -----
// Self-checking bench for the multi-waveform signal generator: a directed table, then
// randomised register settings and tick words with bursty requests and stalled results.
// Depends on mwsg_pkg and multi_waveform_signal_generator.
module multi_waveform_signal_generator_tb;

   localparam int              LATENCY     = 3 + mwsg_pkg::SHAPE_STAGES;
   localparam int              QUIET_LIMIT = 2000;
   localparam int              PHASES      = 8;
   localparam int              WORDS_EACH  = 150;
   localparam int              ROWS        = 23;
   localparam longint unsigned FULL_SCALE  = 64'hFFFF_FFFF;
   localparam longint unsigned UNIT_Q30    = 64'd1 << 30;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned SINE_VMAX   = (64'd1 << mwsg_pkg::SINE_VALUE_BITS) - 1;
   localparam logic [31:0]     ONES        = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        load;
      logic [31:0] mode;
      logic [31:0] amplitude;
      logic [31:0] frequency;
      logic [31:0] offset;
      logic [31:0] position;
      logic        tick;
      logic        pinned;
      logic [31:0] sample;
   } directed_row_type;

   // load, mode, amplitude, frequency, offset, position, tick, pinned, sample
   directed_row_type plan [0:ROWS-1] = '{
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 32'h0},
      '{1'b1, mwsg_pkg::MODE_SINE, 32'h0, 32'h0, 32'h0, ONES, 1'b0, 1'b1, ONES},
      '{1'b1, mwsg_pkg::MODE_SQUARE, ONES, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, ONES},
      '{1'b1, mwsg_pkg::MODE_SQUARE, ONES, 32'h0, 32'h8000_0000, ONES, 1'b0, 1'b1, 32'h0},
      '{1'b1, 32'hFFFF_FFFC | mwsg_pkg::MODE_SQUARE, 32'h1234_5678, 32'h0, 32'h7FFF_FFFF,
        32'h0, 1'b1, 1'b1, 32'h1234_5678},
      '{1'b1, mwsg_pkg::MODE_NONE, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 32'h0},
      '{1'b1, mwsg_pkg::MODE_NONE, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b1, 1'b1,
        32'h8000_0000},
      '{1'b1, mwsg_pkg::MODE_SAW, ONES, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 32'h0},
      '{1'b1, mwsg_pkg::MODE_SAW, ONES, 32'h0, ONES, 32'h0, 1'b0, 1'b1, 32'hFFFF_FFFE},
      '{1'b1, mwsg_pkg::MODE_SINE, ONES, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
      '{1'b1, mwsg_pkg::MODE_SINE, ONES, 32'h0, 32'h4000_0000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{1'b1, mwsg_pkg::MODE_SINE, ONES, 32'h0, 32'hC000_0000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{1'b1, mwsg_pkg::MODE_SINE, 32'h8000_0000, 32'h0, 32'h2000_0000, 32'h5555_5555,
        1'b0, 1'b0, 32'h0},
      '{1'b1, mwsg_pkg::MODE_SAW, ONES, ONES, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
      '{1'b1, mwsg_pkg::MODE_SQUARE, 32'h8000_0000, 32'h4000_0000, 32'h0, ONES,
        1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0},
      '{1'b1, mwsg_pkg::MODE_SINE, 32'hABCD_EF01, 32'h0000_1000, 32'h3, 32'h0000_FFFF,
        1'b1, 1'b0, 32'h0},
      '{1'b1, mwsg_pkg::MODE_SAW, 32'h1, 32'h1, 32'h1, 32'h1, 1'b1, 1'b0, 32'h0}
   };

   logic                                  clock;
   logic                                  reset            = 1'b1;
   logic                                  req_valid        = 1'b0;
   logic                                  req_tick         = 1'b0;
   logic                                  rsp_ready        = 1'b0;
   logic                                  csr_write_enable = 1'b0;
   logic [mwsg_pkg::CSR_INDEX_BITS-1:0]   csr_index        = '0;
   logic [mwsg_pkg::CSR_DATA_BITS-1:0]    csr_write_data   = '0;
   logic                                  req_ready;
   logic                                  rsp_valid;
   logic [mwsg_pkg::SAMPLE_BITS-1:0]      rsp_sample;

   // mirror of the generator state
   mwsg_pkg::mode_type                    cfg_mode      = mwsg_pkg::MODE_SINE;
   logic [31:0]                           cfg_amplitude = '0;
   logic [31:0]                           cfg_frequency = '0;
   logic [31:0]                           cfg_offset    = '0;
   logic [31:0]                           cfg_position  = '0;
   logic [mwsg_pkg::PHASE_BITS-1:0]       phase_acc     = '0;

   logic [31:0]                           samples_due [$];
   logic                                  pinned_on     = 1'b0;
   logic [31:0]                           pinned_sample = '0;
   int unsigned                           words_sent    = 0;
   int unsigned                           words_checked = 0;
   int unsigned                           errors        = 0;
   int unsigned                           quiet_cycles  = 0;
   int unsigned                           ready_style   = 0;
   int unsigned                           style_left    = 0;

   multi_waveform_signal_generator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_tick         (req_tick),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample       (rsp_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // sin of a quarter-wave step in Q30, Taylor series to x^17
   function automatic longint unsigned quarter_turn_sine(input longint unsigned m);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      x    = (m * HALF_PI_Q30) >> (mwsg_pkg::SINE_ADDR_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / longint'(2 * k * (2 * k + 1));
         if (k % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > longint'(UNIT_Q30)) begin
         acc = longint'(UNIT_Q30);
      end
      return longint'(acc);
   endfunction

   function automatic longint unsigned sine_level(input longint unsigned addr);
      longint unsigned n;
      longint unsigned quad;
      longint unsigned r;
      longint unsigned s;
      longint unsigned u;
      n    = 64'd1 << (mwsg_pkg::SINE_ADDR_BITS - 2);
      quad = (addr >> (mwsg_pkg::SINE_ADDR_BITS - 2)) & 64'd3;
      r    = addr & (n - 1);
      s    = quarter_turn_sine(quad[0] ? n - r : r);
      u    = quad[1] ? UNIT_Q30 - s : UNIT_Q30 + s;
      return (SINE_VMAX * u + UNIT_Q30) >> 31;
   endfunction

   function automatic logic [31:0] next_dds_sample(input logic tick);
      logic [mwsg_pkg::PHASE_BITS-1:0] phase;
      longint unsigned                 amp;
      longint unsigned                 wave;
      longint unsigned                 lift;
      longint unsigned                 total;
      if (tick) begin
         phase_acc = phase_acc + mwsg_pkg::PHASE_BITS'(cfg_frequency);
      end
      phase = phase_acc + {cfg_offset, 2'b00};
      amp   = 64'(cfg_amplitude);
      case (cfg_mode)
         mwsg_pkg::MODE_SINE: begin
            wave = (amp * sine_level(64'(phase[mwsg_pkg::PHASE_BITS-1 -:
                                             mwsg_pkg::SINE_ADDR_BITS]))) / SINE_VMAX;
         end
         mwsg_pkg::MODE_SAW: begin
            wave = (amp * 64'(phase[mwsg_pkg::PHASE_BITS-1:2])) >> 32;
         end
         mwsg_pkg::MODE_SQUARE: begin
            wave = phase[mwsg_pkg::PHASE_BITS-1] ? 64'd0 : amp;
         end
         default: begin
            wave = 64'd0;
         end
      endcase
      lift  = ((FULL_SCALE - amp) * 64'(cfg_position)) / FULL_SCALE;
      total = wave + lift;
      if (total > FULL_SCALE) begin
         total = FULL_SCALE;
      end
      return total[31:0];
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(5))
         0: return 32'h0;
         1: return ONES;
         2: return 32'd1 << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   task automatic write_register(input logic [mwsg_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // amplitude and position go first so the lift has settled before the next word
   task automatic load_settings(input logic [31:0] mode, input logic [31:0] amplitude,
                                input logic [31:0] frequency, input logic [31:0] offset,
                                input logic [31:0] position);
      write_register(mwsg_pkg::CSR_AMPLITUDE, amplitude);
      write_register(mwsg_pkg::CSR_POSITION, position);
      write_register(mwsg_pkg::CSR_INDEX_BITS'($urandom_range(2 ** mwsg_pkg::CSR_INDEX_BITS - 1,
                                                               mwsg_pkg::CSR_POSITION + 1)),
                     $urandom);
      write_register(mwsg_pkg::CSR_MODE, mode);
      write_register(mwsg_pkg::CSR_FREQUENCY, frequency);
      write_register(mwsg_pkg::CSR_OFFSET, offset);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_word(input logic tick);
      req_valid <= 1'b1;
      req_tick  <= tick;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_checked != words_sent) @(posedge clock);
   endtask

   always @(posedge clock) begin : sample_check
      logic [31:0] predicted;
      logic [31:0] wanted;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = next_dds_sample(req_tick);
            samples_due.push_back(pinned_on ? pinned_sample : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (samples_due.size() == 0) begin
               $display("%0t: sample %h with none outstanding", $time, rsp_sample);
               errors++;
            end else begin
               wanted = samples_due.pop_front();
               if (wanted !== rsp_sample) begin
                  $display("%0t: sample mismatch, expected %h, got %h", $time, wanted,
                           rsp_sample);
                  errors++;
               end
            end
            words_checked++;
         end
         if (csr_write_enable) begin
            case (csr_index)
               mwsg_pkg::CSR_MODE:
                  cfg_mode = mwsg_pkg::mode_type'(csr_write_data[1:0]);
               mwsg_pkg::CSR_AMPLITUDE: cfg_amplitude = csr_write_data;
               mwsg_pkg::CSR_FREQUENCY: cfg_frequency = csr_write_data;
               mwsg_pkg::CSR_OFFSET:    cfg_offset    = csr_write_data;
               mwsg_pkg::CSR_POSITION:  cfg_position  = csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // result side: always ready, mostly ready, mostly stalled, or a fixed duty pattern
   always @(posedge clock) begin
      if (style_left == 0) begin
         ready_style <= $urandom_range(3);
         style_left  <= $urandom_range(300, 50);
      end else begin
         style_left <= style_left - 1;
      end
      case (ready_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(3) != 0);
         2: rsp_ready <= ($urandom_range(3) == 0);
         default: rsp_ready <= (style_left[4:0] < 5'd6);
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable || reset)
      begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned left;
      int unsigned burst;
      int unsigned gap;
      bit          held;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].load) begin
            load_settings(plan[i].mode, plan[i].amplitude, plan[i].frequency, plan[i].offset,
                          plan[i].position);
         end
         pinned_on     = plan[i].pinned;
         pinned_sample = plan[i].sample;
         send_word(plan[i].tick);
         wait_drain();
      end
      pinned_on = 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         load_settings($urandom, pick_word(), pick_word(), pick_word(), pick_word());
         left = WORDS_EACH;
         held = 1'b0;
         while (left > 0) begin
            burst = $urandom_range(24, 1);
            if (burst > left) begin
               burst = left;
            end
            repeat (burst) begin
               send_word(1'($urandom_range(1)));
               left--;
            end
            // hold off mid-phase until the pipe is empty
            if (p % 4 == 1 && !held && left <= WORDS_EACH / 2) begin
               wait_drain();
               held = 1'b1;
            end else if (p % 3 != 0 && left > 0) begin
               gap = $urandom_range(8);
               if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
         end
         wait_drain();
      end

      repeat (4 * LATENCY) @(posedge clock);
      if (samples_due.size() != 0) begin
         $display("%0t: %0d samples never arrived", $time, samples_due.size());
         errors++;
      end
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
